/* hw/rtl/clcp_pkg.sv */
// Shared widths, register indexes and divider constants for the cubic Lagrange curve unit.
package clcp_pkg;

  // Field widths
  localparam int COORD_W = 9;
  localparam int STEP_W  = 10;
  localparam int OUT_W   = 10;

  // Configuration registers
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT0_X = 3'd0,
    REG_POINT0_Y = 3'd1,
    REG_POINT1_X = 3'd2,
    REG_POINT1_Y = 3'd3,
    REG_POINT2_X = 3'd4,
    REG_POINT2_Y = 3'd5,
    REG_POINT3_X = 3'd6,
    REG_POINT3_Y = 3'd7
  } cfg_reg_t;

  // Polynomial coefficients in powers of k, scaled by 2*10^9
  localparam int EXT_W = 42;
  localparam int A3_W  = 17;
  localparam int A2_W  = 27;
  localparam int A1_W  = 36;
  localparam int A0_W  = 42;

  // Horner partial sums
  localparam int H1_W = 28;
  localparam int H2_W = 38;
  localparam int H3_W = 49;

  // Magnitude and saturation bounds (2e9 * 512 and 2e9 * 513)
  localparam int MAG_W = 48;
  localparam logic [MAG_W-1:0] POS_LIMIT = 48'd1024000000000;
  localparam logic [MAG_W-1:0] NEG_LIMIT = 48'd1026000000000;

  // Divide by 2e9: drop 2^10, then multiply by the reciprocal of 5^9
  localparam int DIV_SHIFT   = 10;
  localparam int QX_W        = 30;
  localparam int RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP = 31'd1152921505;
  localparam int RECIP_SHIFT = 51;
  localparam int PROD_W      = QX_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;

  // Output clamp values
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(511);
  localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(-512);

  // Pipeline depth ahead of the output register
  localparam int PIPE_DEPTH = 6;

endpackage

/* hw/rtl/clcp_if.sv */
// Valid/ready channel interfaces for curve steps and curve points.
interface clcp_step_if;
  logic                        valid;
  logic                        ready;
  logic [clcp_pkg::STEP_W-1:0] step_thousandths;

  modport source (output valid, output step_thousandths, input ready);
  modport sink   (input valid, input step_thousandths, output ready);
endinterface

interface clcp_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [clcp_pkg::OUT_W-1:0] point_x;
  logic signed [clcp_pkg::OUT_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

/* hw/rtl/cubic_lagrange_curve_point_unit.sv */
// An accepted step moves through the stages named below and then shows as a point.
// Throughput: one step per cycle; a stall at the output freezes the whole pipeline.
// The stages are the step input register, three Horner multiplies, a sign/clamp stage,
// the reciprocal multiply for the divide by 2*10^9, and the output register.
// Reset clears all eight point registers to zero and empties the pipeline.
module cubic_lagrange_curve_point_unit (
  input  logic                           clk,
  input  logic                           rst,
  clcp_step_if.sink                      step,
  clcp_point_if.source                   point,
  input  logic                           cfg_wr_en,
  input  logic [clcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clcp_pkg::COORD_W-1:0]   cfg_wdata
);

  logic [clcp_pkg::COORD_W-1:0]      coord [clcp_pkg::NUM_REGS];
  logic [clcp_pkg::PIPE_DEPTH-1:0]   valid;
  logic [clcp_pkg::STEP_W-1:0]       k0, k1, k2;
  logic                              en;
  logic signed [clcp_pkg::OUT_W-1:0] x_value, y_value;

  // Move everything when the output register is empty or being drained
  assign en         = !point.valid || point.ready;
  assign step.ready = en && !rst;

  // Point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coord <= '{default: '0};
    end else if (cfg_wr_en) begin
      coord[cfg_index] <= cfg_wdata;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      point.valid <= 1'b0;
    end else if (en) begin
      valid       <= {valid[clcp_pkg::PIPE_DEPTH-2:0], step.valid};
      point.valid <= valid[clcp_pkg::PIPE_DEPTH-1];
    end
  end

  // Step and result payload
  always_ff @(posedge clk) begin
    if (en) begin
      k0            <= step.step_thousandths;
      k1            <= k0;
      k2            <= k1;
      point.point_x <= x_value;
      point.point_y <= y_value;
    end
  end

  clcp_axis u_axis_x (
    .clk   (clk),
    .en    (en),
    .p0    (coord[clcp_pkg::REG_POINT0_X]),
    .p1    (coord[clcp_pkg::REG_POINT1_X]),
    .p2    (coord[clcp_pkg::REG_POINT2_X]),
    .p3    (coord[clcp_pkg::REG_POINT3_X]),
    .k0    (k0),
    .k1    (k1),
    .k2    (k2),
    .value (x_value)
  );

  clcp_axis u_axis_y (
    .clk   (clk),
    .en    (en),
    .p0    (coord[clcp_pkg::REG_POINT0_Y]),
    .p1    (coord[clcp_pkg::REG_POINT1_Y]),
    .p2    (coord[clcp_pkg::REG_POINT2_Y]),
    .p3    (coord[clcp_pkg::REG_POINT3_Y]),
    .k0    (k0),
    .k1    (k1),
    .k2    (k2),
    .value (y_value)
  );

`ifndef SYNTHESIS
  // A stalled pipeline keeps every in-flight transaction where it is
  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(valid))
    else $error("pipeline valid bits moved during a stall");

  // Reset leaves the pipeline and output empty
  assert property (@(posedge clk) $past(rst) |-> (valid == '0) && !point.valid)
    else $error("pipeline not empty after reset");

  // An accepted step reaches the output if every later stage advances without a stall
  assert property (@(posedge clk) disable iff (rst)
    (step.valid && step.ready) ##1 en ##1 en ##1 en ##1 en ##1 en ##1 en |=> point.valid)
    else $error("accepted step did not reach the output");
`endif

endmodule

/* hw/rtl/clcp_axis.sv */
// One coordinate axis: Horner evaluation of the cubic, constant division and clamp.
module clcp_axis (
  input  logic                              clk,
  input  logic                              en,
  input  logic [clcp_pkg::COORD_W-1:0]      p0,
  input  logic [clcp_pkg::COORD_W-1:0]      p1,
  input  logic [clcp_pkg::COORD_W-1:0]      p2,
  input  logic [clcp_pkg::COORD_W-1:0]      p3,
  input  logic [clcp_pkg::STEP_W-1:0]       k0,
  input  logic [clcp_pkg::STEP_W-1:0]       k1,
  input  logic [clcp_pkg::STEP_W-1:0]       k2,
  output logic signed [clcp_pkg::OUT_W-1:0] value
);

  logic signed [clcp_pkg::EXT_W-1:0] e0, e1, e2, e3;
  logic signed [clcp_pkg::A3_W-1:0]  a3, a3_next;
  logic signed [clcp_pkg::A2_W-1:0]  a2, a2_next;
  logic signed [clcp_pkg::A1_W-1:0]  a1, a1_next;
  logic signed [clcp_pkg::A0_W-1:0]  a0, a0_next;

  logic signed [clcp_pkg::H1_W-1:0]  h1, h1_next, s1_a3, s1_a2, s1_k;
  logic signed [clcp_pkg::H2_W-1:0]  h2, h2_next, s2_h1, s2_a1, s2_k;
  logic signed [clcp_pkg::H3_W-1:0]  h3, h3_next, s3_h2, s3_a0, s3_k;

  logic [clcp_pkg::MAG_W-1:0]        mag;
  logic                              neg4, sat4, neg5, sat5;
  logic [clcp_pkg::QX_W-1:0]         x4;
  logic [clcp_pkg::PROD_W-1:0]       prod;
  logic [clcp_pkg::Q_W-1:0]          q5;

  // Fold the four control points into coefficients of k^3, k^2, k and 1
  always_comb begin
    e0 = signed'(clcp_pkg::EXT_W'(p0));
    e1 = signed'(clcp_pkg::EXT_W'(p1));
    e2 = signed'(clcp_pkg::EXT_W'(p2));
    e3 = signed'(clcp_pkg::EXT_W'(p3));
    a3_next = clcp_pkg::A3_W'(9 * (e3 - e0) + 27 * (e1 - e2));
    a2_next = clcp_pkg::A2_W'(18000 * e0 - 45000 * e1 + 36000 * e2 - 9000 * e3);
    a1_next = clcp_pkg::A1_W'(18000000 * e1 + 2000000 * e3 - 11000000 * e0 - 9000000 * e2);
    a0_next = clcp_pkg::A0_W'(2000000000 * e0);
  end

  // Coefficient regs; user must change points only when pipeline empty, unchecked
  always_ff @(posedge clk) begin
    a3 <= a3_next;
    a2 <= a2_next;
    a1 <= a1_next;
    a0 <= a0_next;
  end

  // Horner steps, one multiply by k per stage
  always_comb begin
    s1_a3   = clcp_pkg::H1_W'(a3);
    s1_a2   = clcp_pkg::H1_W'(a2);
    s1_k    = signed'(clcp_pkg::H1_W'(k0));
    h1_next = s1_a3 * s1_k + s1_a2;

    s2_h1   = clcp_pkg::H2_W'(h1);
    s2_a1   = clcp_pkg::H2_W'(a1);
    s2_k    = signed'(clcp_pkg::H2_W'(k1));
    h2_next = s2_h1 * s2_k + s2_a1;

    s3_h2   = clcp_pkg::H3_W'(h2);
    s3_a0   = clcp_pkg::H3_W'(a0);
    s3_k    = signed'(clcp_pkg::H3_W'(k2));
    h3_next = s3_h2 * s3_k + s3_a0;
  end

  // Split off the sign for truncation toward zero
  assign mag  = clcp_pkg::MAG_W'(h3[clcp_pkg::H3_W-1] ? -h3 : h3);
  assign prod = clcp_pkg::PROD_W'(x4) * clcp_pkg::PROD_W'(clcp_pkg::RECIP);

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      h1   <= h1_next;
      h2   <= h2_next;
      h3   <= h3_next;
      neg4 <= h3[clcp_pkg::H3_W-1];
      sat4 <= h3[clcp_pkg::H3_W-1] ? (mag >= clcp_pkg::NEG_LIMIT)
                                   : (mag >= clcp_pkg::POS_LIMIT);
      x4   <= mag[clcp_pkg::DIV_SHIFT +: clcp_pkg::QX_W];
      neg5 <= neg4;
      sat5 <= sat4;
      q5   <= prod[clcp_pkg::PROD_W-1 -: clcp_pkg::Q_W];
    end
  end

  // Restore the sign, or clamp to the output range
  always_comb begin
    if (sat5) begin
      value = neg5 ? clcp_pkg::OUT_MIN : clcp_pkg::OUT_MAX;
    end else if (neg5) begin
      value = signed'(clcp_pkg::OUT_W'(clcp_pkg::OUT_W'(0) - clcp_pkg::OUT_W'(q5)));
    end else begin
      value = signed'(clcp_pkg::OUT_W'(q5));
    end
  end

endmodule
